FILE: hdl/tsta_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the timed slot table allocator.
// Used by the slot cell, the top level and the port checker; depends on nothing.
package tsta_pkg;

  localparam int SLOTS_DEF  = 8;
  // Slot index wide enough for a table of up to 64 slots.
  localparam int SLOT_IDX_W = 6;

  localparam int FUNC_W  = 2;
  localparam int TIME_W  = 16;
  localparam int COORD_W = 20;
  localparam int RAD_W   = 16;
  localparam int COLOR_W = 24;
  localparam int RSLOT_W = 3;
  localparam int MASK_W  = 8;

  localparam logic [TIME_W-1:0] DURATION_RST = TIME_W'(512);

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SPAWN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                  tick;
    logic [TIME_W-1:0]     dt;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_idx;
    logic [COORD_W-1:0]    cx;
    logic [COORD_W-1:0]    cy;
    logic [RAD_W-1:0]      rad;
    logic [COLOR_W-1:0]    col;
    logic [TIME_W-1:0]     dur;
    logic [RSLOT_W-1:0]    rd_slot;
  } ctl_t;

  // Record handed from cell to cell during a search or read pass.
  typedef struct packed {
    logic                  valid;
    logic                  found_free;
    logic                  have;
    logic [SLOT_IDX_W-1:0] best_idx;
    logic [TIME_W-1:0]     best_time;
    logic                  rd_active;
    logic [COORD_W-1:0]    rd_cx;
    logic [COORD_W-1:0]    rd_cy;
    logic [RAD_W-1:0]      rd_rad;
    logic [COLOR_W-1:0]    rd_col;
    logic [TIME_W-1:0]     rd_rem;
  } carry_t;

endpackage

FILE: hdl/tsta_cell.sv
`timescale 1ns / 1ps
// One slot of the table: its stored entry, its tick update and its stage of the search chain.
// Depends on tsta_pkg.
module tsta_cell import tsta_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  ctl_t   ctl_i,
  input  carry_t carry_i,
  output carry_t carry_o,
  output logic   active_o
);

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_IDX);

  logic               active_r, active_nxt;
  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt;
  logic [COORD_W-1:0] cy_r, cy_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [COLOR_W-1:0] col_r, col_nxt;
  carry_t             carry_r, carry_nxt;

  always_comb begin
    active_nxt = active_r;
    rem_nxt    = rem_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    col_nxt    = col_r;
    if (ctl_i.tick) begin
      if (active_r) begin
        if (rem_r <= ctl_i.dt) begin
          active_nxt = 1'b0;
          rem_nxt    = '0;
        end else begin
          rem_nxt = rem_r - ctl_i.dt;
        end
      end
    end else if (ctl_i.wr_en && (ctl_i.wr_idx == MY_IDX)) begin
      active_nxt = 1'b1;
      rem_nxt    = ctl_i.dur;
      cx_nxt     = ctl_i.cx;
      cy_nxt     = ctl_i.cy;
      rad_nxt    = ctl_i.rad;
      col_nxt    = ctl_i.col;
    end
  end

  // The first free slot wins outright; otherwise the strictly smallest time,
  // so an earlier slot keeps its place on a tie.
  always_comb begin
    carry_nxt = carry_i;
    if (carry_i.valid) begin
      if (!carry_i.found_free) begin
        if (!active_r) begin
          carry_nxt.found_free = 1'b1;
          carry_nxt.best_idx   = MY_IDX;
        end else if (!carry_i.have || (rem_r < carry_i.best_time)) begin
          carry_nxt.have      = 1'b1;
          carry_nxt.best_idx  = MY_IDX;
          carry_nxt.best_time = rem_r;
        end
      end
      if (int'(ctl_i.rd_slot) == CELL_IDX) begin
        carry_nxt.rd_active = active_r;
        carry_nxt.rd_cx     = cx_r;
        carry_nxt.rd_cy     = cy_r;
        carry_nxt.rd_rad    = rad_r;
        carry_nxt.rd_col    = col_r;
        carry_nxt.rd_rem    = rem_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rem_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      rad_r    <= '0;
      col_r    <= '0;
      carry_r  <= '0;
    end else begin
      active_r <= active_nxt;
      rem_r    <= rem_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      rad_r    <= rad_nxt;
      col_r    <= col_nxt;
      carry_r  <= carry_nxt;
    end
  end

  assign carry_o  = carry_r;
  assign active_o = active_r;

endmodule

FILE: hdl/timed_slot_table_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the timed slot table allocator: controller and the row of slot cells.
// Depends on tsta_pkg and tsta_cell.
//
// Usage. Items arrive on the in_ channel (valid/ready) and each gives exactly one result item
// on the out_ channel (valid/ready). A tick item ages every active slot by in_elapsed, a spawn
// item places an entry in the first free slot (or the slot closest to expiry, lowest index
// on ties) and a read item returns the stored entry of in_read_slot.
// The table is a row of SLOTS cells. A spawn or read sends one record down the row, one cell
// per cycle, collecting the search winner and the read data as it goes; the row length thus
// sets the latency. One item is in work at a time.
// After acceptance, a tick or an unused function code passes through S_EXEC and S_FIN, and a
// spawn or read through S_EXEC, S_SCAN and S_FIN, before out_valid; the next item is taken
// as soon as the result has been placed in the output register.
// A stalled receiver holds the result in the output register; the next item is still taken
// and worked on, and it waits in its final state until the output register frees up.
// The lifetime register is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while idle, which the block does not enforce. Reset (rst_n low, synchronous) clears
// the table, sets the lifetime to 512 and empties the output register, with no clearing pass.
module timed_slot_table_allocator_top import tsta_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [TIME_W-1:0]  in_elapsed,
  input  logic [COORD_W-1:0] in_center_x,
  input  logic [COORD_W-1:0] in_center_y,
  input  logic [RAD_W-1:0]   in_radius_in,
  input  logic [COLOR_W-1:0] in_color_in,
  input  logic [RSLOT_W-1:0] in_read_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RSLOT_W-1:0] out_slot,
  output logic               out_evicted,
  output logic               out_entry_active,
  output logic [COORD_W-1:0] out_entry_center_x,
  output logic [COORD_W-1:0] out_entry_center_y,
  output logic [RAD_W-1:0]   out_entry_radius,
  output logic [COLOR_W-1:0] out_entry_color,
  output logic [TIME_W-1:0]  out_entry_remaining,
  output logic [MASK_W-1:0]  out_active_mask,
  input  logic               cfg_wr_en,
  input  logic [TIME_W-1:0]  cfg_wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FIN} state_t;

  state_t             state_r;
  logic [TIME_W-1:0]  duration_r;

  // Captured item.
  logic [FUNC_W-1:0]  func_r;
  logic [TIME_W-1:0]  dt_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic [RAD_W-1:0]   rad_r;
  logic [COLOR_W-1:0] col_r;
  logic [RSLOT_W-1:0] rs_r;

  // Result gathered before it is handed to the output register.
  logic [RSLOT_W-1:0] res_slot_r;
  logic               res_evict_r;
  logic               res_active_r;
  logic [COORD_W-1:0] res_cx_r, res_cy_r;
  logic [RAD_W-1:0]   res_rad_r;
  logic [COLOR_W-1:0] res_col_r;
  logic [TIME_W-1:0]  res_rem_r;

  logic               out_valid_r;
  logic [RSLOT_W-1:0] out_slot_r;
  logic               out_evicted_r;
  logic               out_entry_active_r;
  logic [COORD_W-1:0] out_cx_r, out_cy_r;
  logic [RAD_W-1:0]   out_rad_r;
  logic [COLOR_W-1:0] out_col_r;
  logic [TIME_W-1:0]  out_rem_r;
  logic [MASK_W-1:0]  out_mask_r;

  ctl_t               ctl;
  carry_t             inject;
  carry_t             chain_in  [SLOTS];
  carry_t             chain_out [SLOTS];
  carry_t             tail;
  logic [SLOTS-1:0]   act;
  logic [MASK_W-1:0]  mask;
  logic               is_search;
  logic               out_free;
  logic               out_load;

  assign is_search = (func_r == FUNC_SPAWN) || (func_r == FUNC_READ);
  assign tail      = chain_out[SLOTS-1];
  assign out_free  = !out_valid_r || out_ready;
  // The finished result moves into the output register in this cycle.
  assign out_load  = (state_r == S_FIN) && out_free;

  always_comb begin
    ctl         = '0;
    ctl.tick    = (state_r == S_EXEC) && (func_r == FUNC_TICK);
    ctl.dt      = dt_r;
    ctl.wr_en   = (state_r == S_SCAN) && tail.valid && (func_r == FUNC_SPAWN);
    ctl.wr_idx  = tail.best_idx;
    ctl.cx      = cx_r;
    ctl.cy      = cy_r;
    ctl.rad     = rad_r;
    ctl.col     = col_r;
    ctl.dur     = duration_r;
    // Every search pass looks up this slot, but a spawn drops the read data, so its read fields stay zero.
    ctl.rd_slot = rs_r;
  end

  always_comb begin
    inject       = '0;
    inject.valid = (state_r == S_EXEC) && is_search;
  end

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign chain_in[g] = inject;
      end else begin : g_link
        assign chain_in[g] = chain_out[g-1];
      end
      tsta_cell #(.CELL_IDX(g)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_i    (ctl),
        .carry_i  (chain_in[g]),
        .carry_o  (chain_out[g]),
        .active_o (act[g])
      );
    end
    for (g = 0; g < MASK_W; g++) begin : g_mask
      if (g < SLOTS) begin : g_bit
        assign mask[g] = act[g];
      end else begin : g_zero
        assign mask[g] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      duration_r         <= DURATION_RST;
      out_valid_r        <= 1'b0;
      func_r             <= FUNC_TICK;
      dt_r               <= '0;
      cx_r               <= '0;
      cy_r               <= '0;
      rad_r              <= '0;
      col_r              <= '0;
      rs_r               <= '0;
      res_slot_r         <= '0;
      res_evict_r        <= 1'b0;
      res_active_r       <= 1'b0;
      res_cx_r           <= '0;
      res_cy_r           <= '0;
      res_rad_r          <= '0;
      res_col_r          <= '0;
      res_rem_r          <= '0;
      out_slot_r         <= '0;
      out_evicted_r      <= 1'b0;
      out_entry_active_r <= 1'b0;
      out_cx_r           <= '0;
      out_cy_r           <= '0;
      out_rad_r          <= '0;
      out_col_r          <= '0;
      out_rem_r          <= '0;
      out_mask_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        duration_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r       <= in_func;
            dt_r         <= in_elapsed;
            cx_r         <= in_center_x;
            cy_r         <= in_center_y;
            rad_r        <= in_radius_in;
            col_r        <= in_color_in;
            rs_r         <= in_read_slot;
            res_slot_r   <= '0;
            res_evict_r  <= 1'b0;
            res_active_r <= 1'b0;
            res_cx_r     <= '0;
            res_cy_r     <= '0;
            res_rad_r    <= '0;
            res_col_r    <= '0;
            res_rem_r    <= '0;
            state_r      <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= is_search ? S_SCAN : S_FIN;
        end
        S_SCAN: begin
          if (tail.valid) begin
            if (func_r == FUNC_SPAWN) begin
              res_slot_r  <= RSLOT_W'(tail.best_idx);
              res_evict_r <= !tail.found_free;
            end else begin
              res_slot_r   <= rs_r;
              res_active_r <= tail.rd_active;
              res_cx_r     <= tail.rd_cx;
              res_cy_r     <= tail.rd_cy;
              res_rad_r    <= tail.rd_rad;
              res_col_r    <= tail.rd_col;
              res_rem_r    <= tail.rd_rem;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // The mask is taken here, after any spawn write has landed.
          if (out_free) begin
            out_slot_r         <= res_slot_r;
            out_evicted_r      <= res_evict_r;
            out_entry_active_r <= res_active_r;
            out_cx_r           <= res_cx_r;
            out_cy_r           <= res_cy_r;
            out_rad_r          <= res_rad_r;
            out_col_r          <= res_col_r;
            out_rem_r          <= res_rem_r;
            out_mask_r         <= mask;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_slot            = out_slot_r;
  assign out_evicted         = out_evicted_r;
  assign out_entry_active    = out_entry_active_r;
  assign out_entry_center_x  = out_cx_r;
  assign out_entry_center_y  = out_cy_r;
  assign out_entry_radius    = out_rad_r;
  assign out_entry_color     = out_col_r;
  assign out_entry_remaining = out_rem_r;
  assign out_active_mask     = out_mask_r;

endmodule

FILE: hdl/tsta_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the timed slot table allocator, bound to the top level.
// Depends on tsta_pkg and timed_slot_table_allocator_top.
module tsta_chk import tsta_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [RSLOT_W-1:0] out_slot,
  input logic               out_evicted,
  input logic               out_entry_active,
  input logic [MASK_W-1:0]  out_active_mask
);

  localparam int FULL_BITS = (SLOTS < MASK_W) ? SLOTS : MASK_W;
  localparam logic [MASK_W-1:0] MASK_FULL = MASK_W'((64'd1 << FULL_BITS) - 64'd1);

  // A stalled result stays valid and keeps its slot and its active mask.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_active_mask))
    else $error("result changed while stalled");

  // One item in work at a time: the cycle after an acceptance takes nothing.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // Eviction only happens when every slot was active, and the new entry is active too.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_active_mask == MASK_FULL)
    else $error("eviction with a free slot present");

  // An active entry that was read shows up in the mask.
  a_read_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_active |-> out_active_mask[out_slot])
    else $error("read entry active but mask bit clear");

endmodule

bind timed_slot_table_allocator_top tsta_chk #(.SLOTS(SLOTS)) u_tsta_chk (.*);
